@@ design/gge_pkg.sv @@
// ----------------------------------------------------------------------------
// gge_pkg : shared types, constants and elaboration-time tables
// Word layouts, WGS84 constants, CORDIC arctangent table and gain, and
// the Q60 fixed-point helpers used to derive them.
// ----------------------------------------------------------------------------
package gge_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned ANGLE_BITS_DEF    = 32;
  localparam int unsigned CORDIC_STAGES_DEF = 32;

  // Configuration register indexes.
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned REG_IDX_W     = 3;
  localparam logic [REG_IDX_W-1:0] REG_LON_ORIGIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAT_TOP       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LON_STEP      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LAT_STEP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REF_LAT       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REF_LON       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_OFFSET = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_SPAN   = 3'd7;

  // Pipeline figures.
  localparam int unsigned MUL_LAT      = 2;
  localparam int unsigned NEWTON_STEPS = 8;
  localparam int unsigned RSQ_LAT      = 3 * MUL_LAT + 1;

  // Fixed-point constants in Q60; the semi-major axis (mm) and the inverse-flattening ratio are integers.
  localparam logic signed [63:0] ONE_Q60    = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] THREE_Q60  = 64'sh3000_0000_0000_0000;
  localparam logic signed [63:0] PI_Q60     = 64'sh3243_F6A8_885A_308D;
  localparam logic signed [63:0] TWO_PI_Q60 = 64'sh6487_ED51_10B4_611A;
  localparam logic signed [63:0] SEED_Q60   = ONE_Q60 / 10 * 6;
  localparam logic signed [63:0] SEMI_MAJOR_MM = 64'sd6378137000;
  localparam logic [63:0] INV_FLAT_NUM = 64'd298257223563;
  localparam logic [63:0] INV_FLAT_DEN = 64'd1000000000;
  localparam logic signed [63:0] MAX_Q60 = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] pixel_x;
    logic [31:0] pixel_y;
    logic [15:0] height_fraction;
  } in_word_t;

  typedef struct packed {
    logic signed [35:0] east_mm;
    logic signed [35:0] north_mm;
    logic signed [35:0] up_mm;
  } out_word_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [63:0] sl;
    logic signed [63:0] cl;
    logic signed [63:0] so;
    logic signed [63:0] co;
  } trig_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic [1:0]         quad;
  } cordic_t;

  // (a*b) >> sh, rounded half away from zero, saturated to +/- (2^63-1).
  function automatic logic signed [63:0] smul_f(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int unsigned sh);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    neg  = a[63] ^ b[63];
    ua   = a[63] ? 64'(-a) : 64'(a);
    ub   = b[63] ? 64'(-b) : 64'(b);
    prod = {64'b0, ua} * {64'b0, ub};
    prod = prod + (128'd1 << (sh - 1));
    prod = prod >> sh;
    if (prod[127:63] != '0) begin
      prod = {64'b0, MAX_Q60};
    end
    return neg ? 64'(-$signed(prod[63:0])) : $signed(prod[63:0]);
  endfunction

  function automatic logic signed [63:0] rsqrt_f(input logic signed [63:0] w,
                                                 input logic signed [63:0] y0);
    logic signed [63:0] y;
    logic signed [63:0] t;
    y = y0;
    for (int k = 0; k < NEWTON_STEPS; k++) begin
      t = smul_f(w, smul_f(y, y, 60), 60);
      y = smul_f(y, 64'(THREE_Q60 - t), 61);
    end
    return y;
  endfunction

  // Restoring shift-subtract quotient.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], num[j]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from its power series.
  function automatic logic signed [63:0] atan_val(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int unsigned        k;
    sum = '0;
    if (i == 0) begin
      return PI_Q60 >>> 2;
    end
    k = 0;
    while (i * (2 * k + 1) <= 62) begin
      term = udiv64((64'd1 << 62) >> (i * (2 * k + 1)), 64'(2 * k + 1));
      sum  = k[0] ? sum - $signed(term) : sum + $signed(term);
      k++;
    end
    return (sum + 64'sd2) >>> 2;
  endfunction

  // Reciprocal of the CORDIC gain for a chain of the given length.
  function automatic logic signed [63:0] gain_val(input int unsigned stages);
    logic signed [63:0] g;
    g = ONE_Q60;
    for (int unsigned i = 0; i < stages && i < 64; i++) begin
      if (2 * i <= 62) begin
        g = g + (g >>> (2 * i));
      end
    end
    return rsqrt_f(g, SEED_Q60);
  endfunction

  // First eccentricity squared from the inverse flattening.
  function automatic logic signed [63:0] ecc2_val();
    logic [63:0]        rem;
    logic [63:0]        q;
    logic signed [63:0] f;
    rem = INV_FLAT_DEN;
    q   = '0;
    for (int i = 0; i < 62; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= INV_FLAT_NUM) begin
        rem  = rem - INV_FLAT_NUM;
        q[0] = 1'b1;
      end
    end
    f = $signed((q + 64'd2) >> 2);
    return 64'(2 * f) - smul_f(f, f, 60);
  endfunction

  localparam logic signed [63:0] ECC2_Q60 = ecc2_val();
  localparam logic signed [63:0] OME_Q60  = ONE_Q60 - ECC2_Q60;

endpackage

@@ design/gge_mul.sv @@
// ----------------------------------------------------------------------------
// gge_mul : pipelined 64x64 signed fractional multiplier
// Four 32x32 partial products, then sum, round half away, shift, saturate.
// ----------------------------------------------------------------------------
module gge_mul #(
  parameter int unsigned SH = 60
) (
  input  logic               clk_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o
);

  localparam logic [127:0] RND = 128'd1 << (SH - 1);

  logic [63:0]        ua, ub;
  logic               neg_q;
  logic [63:0]        ll_q, lh_q, hl_q, hh_q;
  logic [127:0]       sum;
  logic [127:0]       shv;
  logic [63:0]        mag;
  logic signed [63:0] p_d, p_q;

  always_comb begin
    ua = a_i[63] ? 64'(-a_i) : 64'(a_i);
    ub = b_i[63] ? 64'(-b_i) : 64'(b_i);
  end

  always_ff @(posedge clk_i) begin
    neg_q <= a_i[63] ^ b_i[63];
    ll_q  <= 64'(ua[31:0])  * 64'(ub[31:0]);
    lh_q  <= 64'(ua[31:0])  * 64'(ub[63:32]);
    hl_q  <= 64'(ua[63:32]) * 64'(ub[31:0]);
    hh_q  <= 64'(ua[63:32]) * 64'(ub[63:32]);
  end

  always_comb begin
    sum = {64'b0, ll_q} + {32'b0, lh_q, 32'b0} + {32'b0, hl_q, 32'b0}
        + {hh_q, 64'b0} + RND;
    shv = sum >> SH;
    mag = (shv[127:63] != '0) ? gge_pkg::MAX_Q60 : shv[63:0];
    p_d = neg_q ? 64'(-$signed(mag)) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ design/gge_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// gge_cordic_cell : one rotation-mode CORDIC micro-rotation
// Shift-add by 2^-IDX, angle update from the arctangent table, one register.
// ----------------------------------------------------------------------------
module gge_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  gge_pkg::cordic_t c_i,
  output gge_pkg::cordic_t c_o
);

  localparam logic signed [63:0] ATAN = gge_pkg::atan_val(IDX);

  logic signed [63:0] dx, dy;
  gge_pkg::cordic_t   c_d, c_q;

  always_comb begin
    dx = $signed(c_i.y) >>> IDX;
    dy = $signed(c_i.x) >>> IDX;
    c_d.quad = c_i.quad;
    if (!c_i.z[63]) begin
      c_d.x = c_i.x - dx;
      c_d.y = c_i.y + dy;
      c_d.z = c_i.z - ATAN;
    end else begin
      c_d.x = c_i.x + dx;
      c_d.y = c_i.y - dy;
      c_d.z = c_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign c_o = c_q;

endmodule

@@ design/gge_sincos.sv @@
// ----------------------------------------------------------------------------
// gge_sincos : sine and cosine of a binary angle
// Angle scaling multiply, a chain of CORDIC cells, quadrant fold-out.
// ----------------------------------------------------------------------------
module gge_sincos #(
  parameter int unsigned ANGLE_BITS    = gge_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = gge_pkg::CORDIC_STAGES_DEF
) (
  input  logic                  clk_i,
  input  logic [ANGLE_BITS-1:0] ang_i,
  output logic signed [63:0]    sin_o,
  output logic signed [63:0]    cos_o
);

  localparam logic signed [63:0] GAIN = gge_pkg::gain_val(CORDIC_STAGES);

  logic signed [63:0] r, z;
  logic [1:0]         quad_q [2];
  gge_pkg::cordic_t   chain [CORDIC_STAGES+1];
  gge_pkg::cordic_t   last;
  logic signed [63:0] sin_q, cos_q;

  assign r = 64'(ang_i[ANGLE_BITS-3:0]);

  // residual angle in radians, Q60
  gge_mul #(.SH(ANGLE_BITS)) u_zmul (
    .clk_i (clk_i),
    .a_i   (r),
    .b_i   (gge_pkg::TWO_PI_Q60),
    .p_o   (z)
  );

  always_ff @(posedge clk_i) begin
    quad_q[0] <= ang_i[ANGLE_BITS-1:ANGLE_BITS-2];
    quad_q[1] <= quad_q[0];
  end

  always_comb begin
    chain[0].x    = GAIN;
    chain[0].y    = '0;
    chain[0].z    = z;
    chain[0].quad = quad_q[1];
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    gge_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .c_i   (chain[i]),
      .c_o   (chain[i+1])
    );
  end

  assign last = chain[CORDIC_STAGES];

  always_ff @(posedge clk_i) begin
    case (last.quad)
      2'd0: begin
        cos_q <= last.x;
        sin_q <= last.y;
      end
      2'd1: begin
        cos_q <= 64'(-last.y);
        sin_q <= last.x;
      end
      2'd2: begin
        cos_q <= 64'(-last.x);
        sin_q <= 64'(-last.y);
      end
      default: begin
        cos_q <= last.y;
        sin_q <= 64'(-last.x);
      end
    endcase
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

@@ design/gge_rsqrt_cell.sv @@
// ----------------------------------------------------------------------------
// gge_rsqrt_cell : one Newton step toward 1/sqrt(w)
// y' = y * (3 - w*y*y) / 2 in Q60; w rides along.
// ----------------------------------------------------------------------------
module gge_rsqrt_cell (
  input  logic               clk_i,
  input  logic signed [63:0] w_i,
  input  logic signed [63:0] y_i,
  output logic signed [63:0] w_o,
  output logic signed [63:0] y_o
);

  logic signed [63:0] wd_q [7];
  logic signed [63:0] yd_q [5];
  logic signed [63:0] yy, t, s_q;

  always_ff @(posedge clk_i) begin
    wd_q[0] <= w_i;
    yd_q[0] <= y_i;
    for (int j = 1; j < 7; j++) begin
      wd_q[j] <= wd_q[j-1];
    end
    for (int j = 1; j < 5; j++) begin
      yd_q[j] <= yd_q[j-1];
    end
  end

  gge_mul #(.SH(60)) u_yy (.clk_i(clk_i), .a_i(y_i),     .b_i(y_i), .p_o(yy));
  gge_mul #(.SH(60)) u_wt (.clk_i(clk_i), .a_i(wd_q[1]), .b_i(yy),  .p_o(t));

  always_ff @(posedge clk_i) begin
    s_q <= gge_pkg::THREE_Q60 - t;
  end

  gge_mul #(.SH(61)) u_yn (.clk_i(clk_i), .a_i(yd_q[4]), .b_i(s_q), .p_o(y_o));

  assign w_o = wd_q[6];

endmodule

@@ design/gge_ecef.sv @@
// ----------------------------------------------------------------------------
// gge_ecef : geodetic angles and height to earth-centred position
// Two sine/cosine chains, prime-vertical radius by Newton cells, then the
// WGS84 position products. Q16 mm out, trig values out alongside.
// ----------------------------------------------------------------------------
module gge_ecef #(
  parameter int unsigned ANGLE_BITS    = gge_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = gge_pkg::CORDIC_STAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [ANGLE_BITS-1:0] lat_i,
  input  logic [ANGLE_BITS-1:0] lon_i,
  input  logic signed [63:0]    h_i,
  output logic                  vld_o,
  output gge_pkg::vec3_t        p_o,
  output gge_pkg::trig_t        trig_o
);

  localparam int unsigned NS = gge_pkg::NEWTON_STEPS;
  localparam int unsigned LS = CORDIC_STAGES + 3;                  // trig ready
  localparam int unsigned LW = LS + 2 * gge_pkg::MUL_LAT + 1;      // w ready
  localparam int unsigned LN = LW + NS * gge_pkg::RSQ_LAT;          // nf ready
  localparam int unsigned T0 = LN + gge_pkg::MUL_LAT;              // n ready
  localparam int unsigned LE = T0 + 2 * gge_pkg::MUL_LAT + 1;      // p ready

  logic [LE-1:0]      vld_q;
  logic signed [63:0] sl_s, cl_s, so_s, co_s;
  gge_pkg::trig_t     tdl_q [LE-LS];
  logic signed [63:0] hdl_q [T0+2];
  logic signed [63:0] ss, es, w_q;
  logic signed [63:0] wc [NS];
  logic signed [63:0] yc [NS+1];
  logic signed [63:0] n, m, nh_q, z2_q, a;
  logic signed [63:0] px, py, pz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LE-2:0], vld_i};
    end
  end

  gge_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lat (
    .clk_i (clk_i), .ang_i (lat_i), .sin_o (sl_s), .cos_o (cl_s)
  );
  gge_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lon (
    .clk_i (clk_i), .ang_i (lon_i), .sin_o (so_s), .cos_o (co_s)
  );

  // trig and height delay lines, entry k holds the value one stage later
  always_ff @(posedge clk_i) begin
    tdl_q[0].sl <= sl_s;
    tdl_q[0].cl <= cl_s;
    tdl_q[0].so <= so_s;
    tdl_q[0].co <= co_s;
    for (int k = 1; k < LE - LS; k++) begin
      tdl_q[k] <= tdl_q[k-1];
    end
    hdl_q[0] <= h_i;
    for (int k = 1; k < T0 + 2; k++) begin
      hdl_q[k] <= hdl_q[k-1];
    end
  end

  // w = 1 - e^2 sin^2(lat)
  gge_mul #(.SH(60)) u_ss (.clk_i(clk_i), .a_i(sl_s), .b_i(sl_s), .p_o(ss));
  gge_mul #(.SH(60)) u_es (.clk_i(clk_i), .a_i(gge_pkg::ECC2_Q60), .b_i(ss), .p_o(es));

  always_ff @(posedge clk_i) begin
    w_q <= gge_pkg::ONE_Q60 - es;
  end

  assign wc[0] = w_q;
  assign yc[0] = gge_pkg::ONE_Q60;

  for (genvar i = 0; i < NS; i++) begin : g_newton
    if (i < NS - 1) begin : g_mid
      gge_rsqrt_cell u_rsq (
        .clk_i (clk_i), .w_i (wc[i]), .y_i (yc[i]), .w_o (wc[i+1]), .y_o (yc[i+1])
      );
    end else begin : g_end
      gge_rsqrt_cell u_rsq (
        .clk_i (clk_i), .w_i (wc[i]), .y_i (yc[i]), .w_o (), .y_o (yc[i+1])
      );
    end
  end

  // prime-vertical radius in Q16 mm
  gge_mul #(.SH(44)) u_n (
    .clk_i (clk_i), .a_i (gge_pkg::SEMI_MAJOR_MM), .b_i (yc[NS]), .p_o (n)
  );
  gge_mul #(.SH(60)) u_m (
    .clk_i (clk_i), .a_i (n), .b_i (gge_pkg::OME_Q60), .p_o (m)
  );

  always_ff @(posedge clk_i) begin
    nh_q <= n + hdl_q[T0-1];
    z2_q <= m + hdl_q[T0+1];
  end

  gge_mul #(.SH(60)) u_a (
    .clk_i (clk_i), .a_i (nh_q), .b_i (tdl_q[T0-LS].cl), .p_o (a)
  );
  gge_mul #(.SH(60)) u_px (
    .clk_i (clk_i), .a_i (a), .b_i (tdl_q[T0+2-LS].co), .p_o (px)
  );
  gge_mul #(.SH(60)) u_py (
    .clk_i (clk_i), .a_i (a), .b_i (tdl_q[T0+2-LS].so), .p_o (py)
  );
  gge_mul #(.SH(60)) u_pz (
    .clk_i (clk_i), .a_i (z2_q), .b_i (tdl_q[T0+2-LS].sl), .p_o (pz)
  );

  assign vld_o  = vld_q[LE-1];
  assign p_o.x  = px;
  assign p_o.y  = py;
  assign p_o.z  = pz;
  assign trig_o = tdl_q[LE-LS-1];

endmodule

@@ design/geodetic_grid_to_enu_top.sv @@
// ----------------------------------------------------------------------------
// geodetic_grid_to_enu_top : terrain grid point to local east-north-up mm
// Path: an accepted start is registered, then passes the CORDIC cell chain
//   and eight Newton cells before the position, difference and rotation
//   products that lead to the result strobe.
// Throughput: one word per cycle; busy never rises and results cannot stall.
// Reset: rst_ni clears the configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module geodetic_grid_to_enu_top #(
  parameter int unsigned ANGLE_BITS    = gge_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = gge_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  gge_pkg::in_word_t                 in_i,
  // result side, one word per strobe
  output logic                              out_strobe_o,
  output gge_pkg::out_word_t                out_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [gge_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i
);

  logic [31:0]           cfg_q [gge_pkg::NUM_REGS];

  logic signed [64:0]    lon_prod, lat_prod;
  logic signed [63:0]    h_prod;
  logic [63:0]           lon64, lat64, rlat64, rlon64;
  logic signed [63:0]    h_d;

  logic                  vld_a_q;
  logic [ANGLE_BITS-1:0] lat_a_q, lon_a_q, rlat_a_q, rlon_a_q;
  logic signed [63:0]    h_a_q;

  logic                  vm, vr;
  gge_pkg::vec3_t        pm, pr;
  gge_pkg::trig_t        tr, tr1_q, tr2_q;
  gge_pkg::vec3_t        d1_q, d2_q;
  logic [5:0]            vs_q;

  logic signed [63:0]    n0m, n1m, u0, u1;
  logic signed [63:0]    e0, e1, k0, k1, k2, q0, q1, q2;
  logic signed [63:0]    east_q, north_q, up_q;
  gge_pkg::out_word_t    out_q;

  // Round Q16 mm to mm and clip to the 36-bit output range.
  function automatic logic signed [35:0] to_mm(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic signed [47:0] s;
    r = v + 64'sd32768;
    s = r[63:16];
    if ((&s[47:35]) || !(|s[47:35])) begin
      return s[35:0];
    end
    return s[47] ? {1'b1, 35'b0} : {1'b0, {35{1'b1}}};
  endfunction

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gge_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // grid position to turn fractions (64-bit, wrap mod one turn) and height
  always_comb begin
    lon_prod = $signed(cfg_q[gge_pkg::REG_LON_STEP]) * $signed({1'b0, in_i.pixel_x});
    lat_prod = $signed(cfg_q[gge_pkg::REG_LAT_STEP]) * $signed({1'b0, in_i.pixel_y});
    h_prod   = $signed(cfg_q[gge_pkg::REG_HEIGHT_SPAN])
             * $signed({1'b0, in_i.height_fraction});
    lon64    = {cfg_q[gge_pkg::REG_LON_ORIGIN], 32'b0} + lon_prod[63:0];
    lat64    = {cfg_q[gge_pkg::REG_LAT_TOP], 32'b0} - lat_prod[63:0];
    rlat64   = {cfg_q[gge_pkg::REG_REF_LAT], 32'b0};
    rlon64   = {cfg_q[gge_pkg::REG_REF_LON], 32'b0};
    h_d      = $signed({{16{cfg_q[gge_pkg::REG_HEIGHT_OFFSET][31]}},
                        cfg_q[gge_pkg::REG_HEIGHT_OFFSET], 16'b0}) + h_prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    lat_a_q  <= lat64[63 -: ANGLE_BITS];
    lon_a_q  <= lon64[63 -: ANGLE_BITS];
    rlat_a_q <= rlat64[63 -: ANGLE_BITS];
    rlon_a_q <= rlon64[63 -: ANGLE_BITS];
    h_a_q    <= h_d;
  end

  // grid point and reference point run side by side, so every word sees
  // the reference of the registers it was started with
  gge_ecef #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pt (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (vld_a_q),
    .lat_i (lat_a_q), .lon_i (lon_a_q), .h_i (h_a_q),
    .vld_o (vm), .p_o (pm), .trig_o ()
  );
  gge_ecef #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_ref (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (vld_a_q),
    .lat_i (rlat_a_q), .lon_i (rlon_a_q), .h_i (64'sd0),
    .vld_o (vr), .p_o (pr), .trig_o (tr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
    end else begin
      vs_q <= {vs_q[4:0], vm && vr};
    end
  end

  // difference vector, trig aligned to the rotation products
  always_ff @(posedge clk_i) begin
    d1_q.x <= pm.x - pr.x;
    d1_q.y <= pm.y - pr.y;
    d1_q.z <= pm.z - pr.z;
    d2_q   <= d1_q;
    tr1_q  <= tr;
    tr2_q  <= tr1_q;
  end

  // rotation matrix terms (north row kept un-negated, sign folded into the sum)
  gge_mul #(.SH(60)) u_n0 (.clk_i(clk_i), .a_i(tr.sl), .b_i(tr.co), .p_o(n0m));
  gge_mul #(.SH(60)) u_n1 (.clk_i(clk_i), .a_i(tr.sl), .b_i(tr.so), .p_o(n1m));
  gge_mul #(.SH(60)) u_u0 (.clk_i(clk_i), .a_i(tr.cl), .b_i(tr.co), .p_o(u0));
  gge_mul #(.SH(60)) u_u1 (.clk_i(clk_i), .a_i(tr.cl), .b_i(tr.so), .p_o(u1));

  gge_mul #(.SH(60)) u_e0 (.clk_i(clk_i), .a_i(tr2_q.so), .b_i(d2_q.x), .p_o(e0));
  gge_mul #(.SH(60)) u_e1 (.clk_i(clk_i), .a_i(tr2_q.co), .b_i(d2_q.y), .p_o(e1));
  gge_mul #(.SH(60)) u_k0 (.clk_i(clk_i), .a_i(n0m),      .b_i(d2_q.x), .p_o(k0));
  gge_mul #(.SH(60)) u_k1 (.clk_i(clk_i), .a_i(n1m),      .b_i(d2_q.y), .p_o(k1));
  gge_mul #(.SH(60)) u_k2 (.clk_i(clk_i), .a_i(tr2_q.cl), .b_i(d2_q.z), .p_o(k2));
  gge_mul #(.SH(60)) u_q0 (.clk_i(clk_i), .a_i(u0),       .b_i(d2_q.x), .p_o(q0));
  gge_mul #(.SH(60)) u_q1 (.clk_i(clk_i), .a_i(u1),       .b_i(d2_q.y), .p_o(q1));
  gge_mul #(.SH(60)) u_q2 (.clk_i(clk_i), .a_i(tr2_q.sl), .b_i(d2_q.z), .p_o(q2));

  always_ff @(posedge clk_i) begin
    east_q  <= e1 - e0;
    north_q <= k2 - k0 - k1;
    up_q    <= q0 + q1 + q2;
    out_q.east_mm  <= to_mm(east_q);
    out_q.north_mm <= to_mm(north_q);
    out_q.up_mm    <= to_mm(up_q);
  end

  assign out_strobe_o = vs_q[5];
  assign out_o        = out_q;

endmodule
